// ===== hdl/indexed_priority_queue_assert.svh =====
// Assertion macros shared by the checker of the indexed priority queue.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef INDEXED_PRIORITY_QUEUE_ASSERT_SVH
`define INDEXED_PRIORITY_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ipq_pkg.sv =====
// Package of the indexed priority queue: opcodes, status codes and sequencer states.
// It has no dependencies and is compiled before every other file.
package ipq_pkg;

    localparam int OP_BITS     = 3;
    localparam int STATUS_BITS = 3;

    typedef enum logic [OP_BITS-1:0] {
        OP_INSERT = 3'd0,
        OP_POP    = 3'd1,
        OP_PEEK   = 3'd2,
        OP_ERASE  = 3'd3,
        OP_CLEAR  = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_DUPLICATE = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PLACE,
        S_FRONT_RD,
        S_FRONT_CHK,
        S_OUT
    } state_t;

endpackage

// ===== hdl/ipq_if.sv =====
// Valid/ready channel interfaces of the indexed priority queue.
// Depends on ipq_pkg for the opcode and status widths.
interface ipq_cmd_if #(
    parameter int ID_BITS  = 12,
    parameter int KEY_BITS = 32
);
    import ipq_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_BITS-1:0]  opcode;
    logic [ID_BITS-1:0]  vertex_id;
    logic [KEY_BITS-1:0] cost_key;

    modport source (output valid, output opcode, output vertex_id, output cost_key,
                    input ready);
    modport sink   (input valid, input opcode, input vertex_id, input cost_key,
                    output ready);
endinterface

interface ipq_rsp_if #(
    parameter int ID_BITS  = 12,
    parameter int KEY_BITS = 32,
    parameter int CNT_BITS = 9
);
    import ipq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [ID_BITS-1:0]     front_id;
    logic [KEY_BITS-1:0]    front_key;
    logic [CNT_BITS-1:0]    entry_count;

    modport source (output valid, output status, output front_id, output front_key,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input front_id, input front_key,
                    input entry_count, output ready);
endinterface

// ===== hdl/indexed_priority_queue.sv =====
// Indexed priority queue of (vertex id, cost key) entries, best key first.
// A command word arrives on cmd (opcode, vertex_id, cost_key) and is taken when
// cmd.valid and cmd.ready are both high; exactly one response word leaves on rsp
// (status, front_id, front_key, entry_count). The sort order is set by the single
// configuration bit, written through cfg_we and cfg_wdata; the user must write it
// only while the queue is idle, as the block itself does not enforce this. Entries
// live in a sorted chain in one memory with a registered read port, front at
// slot 0. A small sequencer drives one id/key comparator over that chain, and each
// slot visited is first read: a scan for the id and the insert position reads and
// then checks each entry examined, and every entry moved by an insert, pop or
// erase is read and then written one slot on. Deciding, placing, reading the front
// back and loading the response are steps of their own. cmd.ready is high only
// while the sequencer is idle. The response sits in an output register, so a
// stalled receiver holds only that word; the next command is still accepted and
// runs until its own response is ready to be loaded. Reset empties the queue and
// selects smallest-key-first order; memory contents are not cleared.
module indexed_priority_queue #(
    parameter int CAPACITY = 256,
    parameter int ID_BITS  = 12,
    parameter int KEY_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    ipq_cmd_if.sink    cmd,
    ipq_rsp_if.source  rsp
);
    import ipq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // Sequencer and working registers.
    state_t                 state_reg, state_next;
    logic [OP_BITS-1:0]     op_reg, op_next;
    logic [ID_BITS-1:0]     id_reg, id_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          pos_reg, pos_next;
    logic                   hit_reg, hit_next;
    logic                   pos_found_reg, pos_found_next;
    logic [STATUS_BITS-1:0] status_reg, status_next;
    logic [ID_BITS-1:0]     fid_reg, fid_next;
    logic [KEY_BITS-1:0]    fkey_reg, fkey_next;
    logic                   desc_reg;

    // Response register.
    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_BITS-1:0] out_status_reg, out_status_next;
    logic [ID_BITS-1:0]     out_id_reg, out_id_next;
    logic [KEY_BITS-1:0]    out_key_reg, out_key_next;
    logic [CW-1:0]          out_count_reg, out_count_next;

    // Memory port signals.
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [ID_BITS-1:0]  wr_id;
    logic [KEY_BITS-1:0] wr_key;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [ID_BITS-1:0]  rd_id;
    logic [KEY_BITS-1:0] rd_key;

    // Shared compare unit and index arithmetic.
    logic          id_match;
    logic          stays_ahead;
    logic          is_insert;
    logic          is_pop;
    logic          out_free;
    logic          scan_last;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] idx_inc2;
    logic [CW-1:0] idx_dec;
    logic [CW-1:0] pos_inc;
    logic [CW-1:0] shift_src;
    state_t        done_state;

    ipq_store #(
        .DEPTH    (CAPACITY),
        .ID_BITS  (ID_BITS),
        .KEY_BITS (KEY_BITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_id   (wr_id),
        .wr_key  (wr_key),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_id   (rd_id),
        .rd_key  (rd_key)
    );

    // The stored entry stays ahead of the new one when it is no worse; equal keys
    // keep the older entry in front.
    assign id_match    = (rd_id == id_reg);
    assign stays_ahead = desc_reg ? (rd_key >= key_reg) : (rd_key <= key_reg);
    assign is_insert   = (op_reg == OP_INSERT);
    assign is_pop      = (op_reg == OP_POP);
    assign out_free    = !out_valid_reg || rsp.ready;
    assign idx_inc     = idx_reg + CW'(1);
    assign idx_inc2    = idx_reg + CW'(2);
    assign idx_dec     = idx_reg - CW'(1);
    assign pos_inc     = pos_reg + CW'(1);
    assign scan_last   = (idx_inc == count_reg);
    assign shift_src   = is_insert ? idx_dec : idx_inc;
    // A pop has already latched its front word before the chain is closed up.
    assign done_state  = is_pop ? S_OUT : S_FRONT_RD;

    assign cmd.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.front_id    = out_id_reg;
    assign rsp.front_key   = out_key_reg;
    assign rsp.entry_count = out_count_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    unique case (cmd.opcode) inside
                        OP_INSERT, OP_ERASE:
                            state_next = (count_reg == '0) ? S_DECIDE : S_SCAN_RD;
                        OP_POP:
                            state_next = (count_reg == '0) ? S_OUT : S_FRONT_RD;
                        default:
                            state_next = S_FRONT_RD;
                    endcase
                end
            end
            S_SCAN_RD:
                state_next = S_SCAN_CHK;
            S_SCAN_CHK:
                state_next = (id_match || scan_last) ? S_DECIDE : S_SCAN_RD;
            S_DECIDE:
            begin
                if (is_insert)
                begin
                    if (hit_reg || count_reg == CW'(CAPACITY))
                        state_next = S_FRONT_RD;
                    else if (pos_reg == count_reg)
                        state_next = S_PLACE;
                    else
                        state_next = S_SHIFT_RD;
                end
                else
                begin
                    if (!hit_reg)
                        state_next = S_FRONT_RD;
                    else if (pos_inc == count_reg)
                        state_next = done_state;
                    else
                        state_next = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD:
                state_next = S_SHIFT_WR;
            S_SHIFT_WR:
            begin
                if (is_insert)
                    state_next = (idx_dec == pos_reg) ? S_PLACE : S_SHIFT_RD;
                else
                    state_next = (idx_inc2 == count_reg) ? done_state : S_SHIFT_RD;
            end
            S_PLACE:
                state_next = S_FRONT_RD;
            S_FRONT_RD:
                state_next = (count_reg == '0) ? S_OUT : S_FRONT_CHK;
            S_FRONT_CHK:
                state_next = is_pop ? S_DECIDE : S_OUT;
            S_OUT:
                state_next = out_free ? S_IDLE : S_OUT;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Datapath, memory control and response register.
    always_comb
    begin
        op_next         = op_reg;
        id_next         = id_reg;
        key_next        = key_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        hit_next        = hit_reg;
        pos_found_next  = pos_found_reg;
        status_next     = status_reg;
        fid_next        = fid_reg;
        fkey_next       = fkey_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_key_next    = out_key_reg;
        out_count_next  = out_count_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg[AW-1:0];
        wr_id           = rd_id;
        wr_key          = rd_key;
        rd_en           = 1'b0;
        rd_addr         = idx_reg[AW-1:0];

        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next        = cmd.opcode;
                    id_next        = cmd.vertex_id;
                    key_next       = cmd.cost_key;
                    idx_next       = '0;
                    pos_next       = count_reg;
                    hit_next       = 1'b0;
                    pos_found_next = 1'b0;
                    status_next    = ST_OK;
                    unique case (cmd.opcode) inside
                        OP_POP, OP_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                fid_next    = '0;
                                fkey_next   = '0;
                            end
                        end
                        OP_CLEAR:
                            count_next = '0;
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_reg[AW-1:0];
            end
            S_SCAN_CHK:
            begin
                if (id_match)
                begin
                    hit_next = 1'b1;
                    pos_next = idx_reg;
                end
                else if (is_insert && !pos_found_reg && !stays_ahead)
                begin
                    pos_next       = idx_reg;
                    pos_found_next = 1'b1;
                end
                idx_next = idx_inc;
            end
            S_DECIDE:
            begin
                if (is_insert)
                begin
                    if (hit_reg)
                        status_next = ST_DUPLICATE;
                    else if (count_reg == CW'(CAPACITY))
                        status_next = ST_FULL;
                    else
                        idx_next = count_reg;
                end
                else
                begin
                    if (!hit_reg)
                        status_next = ST_NOT_FOUND;
                    else if (pos_inc == count_reg)
                        count_next = count_reg - CW'(1);
                    else
                        idx_next = pos_reg;
                end
            end
            S_SHIFT_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = shift_src[AW-1:0];
            end
            S_SHIFT_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg[AW-1:0];
                wr_id   = rd_id;
                wr_key  = rd_key;
                if (is_insert)
                    idx_next = idx_dec;
                else
                begin
                    idx_next = idx_inc;
                    if (idx_inc2 == count_reg)
                        count_next = count_reg - CW'(1);
                end
            end
            S_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg[AW-1:0];
                wr_id      = id_reg;
                wr_key     = key_reg;
                count_next = count_reg + CW'(1);
            end
            S_FRONT_RD:
            begin
                if (count_reg == '0)
                begin
                    fid_next  = '0;
                    fkey_next = '0;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = '0;
                end
            end
            S_FRONT_CHK:
            begin
                fid_next  = rd_id;
                fkey_next = rd_key;
                if (is_pop)
                begin
                    pos_next = '0;
                    hit_next = 1'b1;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_id_next     = fid_reg;
                    out_key_next    = fkey_reg;
                    out_count_next  = count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            desc_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                desc_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        key_reg        <= key_next;
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        hit_reg        <= hit_next;
        pos_found_reg  <= pos_found_next;
        status_reg     <= status_next;
        fid_reg        <= fid_next;
        fkey_reg       <= fkey_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_key_reg    <= out_key_next;
        out_count_reg  <= out_count_next;
    end

endmodule

// ===== hdl/ipq_store.sv =====
// Slot memory of the indexed priority queue: one write port and one registered read port.
// Depends on nothing but its parameters.
module ipq_store #(
    parameter int DEPTH    = 256,
    parameter int ID_BITS  = 12,
    parameter int KEY_BITS = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [ID_BITS-1:0]       wr_id,
    input  logic [KEY_BITS-1:0]      wr_key,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [ID_BITS-1:0]       rd_id,
    output logic [KEY_BITS-1:0]      rd_key
);

    logic [ID_BITS-1:0]  id_mem  [DEPTH];
    logic [KEY_BITS-1:0] key_mem [DEPTH];
    logic [ID_BITS-1:0]  rd_id_reg;
    logic [KEY_BITS-1:0] rd_key_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            id_mem[wr_addr]  <= wr_id;
            key_mem[wr_addr] <= wr_key;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_id_reg  <= id_mem[rd_addr];
            rd_key_reg <= key_mem[rd_addr];
        end
    end

    assign rd_id  = rd_id_reg;
    assign rd_key = rd_key_reg;

endmodule

// ===== hdl/ipq_checker.sv =====
// Port-level checker of the indexed priority queue, bound to the top level below.
// Depends on ipq_pkg and on the assertion macros in indexed_priority_queue_assert.svh.
`include "indexed_priority_queue_assert.svh"

module ipq_checker #(
    parameter int CAPACITY = 256,
    parameter int ID_BITS  = 12,
    parameter int KEY_BITS = 32,
    parameter int CNT_BITS = 9
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            cmd_valid,
    input logic                            cmd_ready,
    input logic                            rsp_valid,
    input logic                            rsp_ready,
    input logic [ipq_pkg::STATUS_BITS-1:0] rsp_status,
    input logic [ID_BITS-1:0]              rsp_front_id,
    input logic [KEY_BITS-1:0]             rsp_front_key,
    input logic [CNT_BITS-1:0]             rsp_entry_count
);
    import ipq_pkg::*;

    // A response word is held until the receiver takes it.
    `IPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

    // Every accepted command leaves the sequencer busy in the following cycle.
    `IPQ_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready, "ready stayed high after a command was taken")

    // A new response is only loaded when the sequencer was busy finishing a command.
    `IPQ_ASSERT_SAME(a_rsp_from_busy, $rose(rsp_valid), $past(!cmd_ready), "response appeared without a command in progress")

    // An empty report carries a cleared front and an empty count.
    `IPQ_ASSERT_SAME(a_empty_front, rsp_valid && rsp_status == ST_EMPTY, rsp_front_id == '0 && rsp_front_key == '0 && rsp_entry_count == '0, "empty status with a nonzero front or count")

    // The count never goes past the capacity.
    `IPQ_ASSERT_SAME(a_count_bound, rsp_valid, int'(rsp_entry_count) <= CAPACITY, "entry count beyond capacity")

endmodule

bind indexed_priority_queue ipq_checker #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS),
    .KEY_BITS (KEY_BITS),
    .CNT_BITS ($clog2(CAPACITY + 1))
) u_ipq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_front_id    (rsp.front_id),
    .rsp_front_key   (rsp.front_key),
    .rsp_entry_count (rsp.entry_count)
);
